FILE: rtl/core/usb_bulk_to_ethernet_frame_assembler_defines.svh
// Assertion macros shared by the frame assembler files.
`ifndef USB_BULK_TO_ETHERNET_FRAME_ASSEMBLER_DEFINES_SVH
`define USB_BULK_TO_ETHERNET_FRAME_ASSEMBLER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that post holds in the same cycle as pre.
`define USBETH_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("usbeth: same-cycle check failed");
// Check that post holds in the cycle after pre.
`define USBETH_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("usbeth: next-cycle check failed");
`else
`define USBETH_ASSERT_IMPLY(label, clk, rst, pre, post)
`define USBETH_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: rtl/core/usbeth_pkg.sv
package usbeth_pkg;

   // Default sizing
   localparam int FRAME_BYTES_DEF = 2048;
   localparam int MIN_FRAME_DEF = 64;

   // Ethernet header layout
   localparam int HEADER_BYTES = 14;
   localparam int ETYPE_HI_POS = 12;
   localparam int ETYPE_LO_POS = 13;
   localparam logic [15:0] TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] TYPE_ARP = 16'h0806;

   // Packet byte counter saturation and register reset
   localparam logic [10:0] PKT_SAT = 11'd2047;
   localparam logic [10:0] MPS_RESET = 11'd64;

   // Register index (word address bit)
   localparam logic REG_MAX_PACKET_SIZE = 1'b0;

   // Queue sizing
   localparam int CMD_DEPTH = 2;
   localparam int CMD_AW = 1;
   localparam int CMD_CW = 2;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW = 2;
   localparam int RSP_CW = 3;

   // Input opcodes
   typedef enum logic [2:0] {
      OP_DATA     = 3'd0,
      OP_PKT_END  = 3'd1,
      OP_NAK      = 3'd2,
      OP_XFER_ERR = 3'd3,
      OP_READ     = 3'd4
   } opcode_type;

   // Classified commands handed from front to back
   typedef enum logic [2:0] {
      CMD_DATA      = 3'd0,
      CMD_PKT_END   = 3'd1,
      CMD_XFER_ERR  = 3'd2,
      CMD_LINK_DOWN = 3'd3,
      CMD_READ      = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_READY   = 2'd1,
      KIND_DISCARD = 2'd2
   } result_kind_type;

   typedef struct packed {
      result_kind_type kind;
      logic [11:0]     length;
      logic [7:0]      data;
      logic            last;
   } result_type;

endpackage

FILE: rtl/core/usbeth_front.sv
module usbeth_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [2:0]          opcode,
   input  logic [7:0]          data_byte,
   input  logic                link_up,
   output logic                cmd_valid,
   output usbeth_pkg::cmd_type cmd,
   input  logic                cmd_pop
);

   usbeth_pkg::cmd_type cls;
   logic keep;
   logic wr_en;

   usbeth_pkg::cmd_type             q_ff [usbeth_pkg::CMD_DEPTH];
   logic [usbeth_pkg::CMD_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [usbeth_pkg::CMD_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [usbeth_pkg::CMD_CW-1:0]   count_ff, count_in;

   // Classify the incoming word; drop words that change nothing
   always_comb begin
      keep = 1'b1;
      cls.data = data_byte;
      cls.kind = usbeth_pkg::CMD_DATA;
      if (opcode == usbeth_pkg::OP_READ) begin
         cls.kind = usbeth_pkg::CMD_READ;
      end else if (!link_up) begin
         cls.kind = usbeth_pkg::CMD_LINK_DOWN;
      end else begin
         unique case (usbeth_pkg::opcode_type'(opcode))
            usbeth_pkg::OP_DATA:     cls.kind = usbeth_pkg::CMD_DATA;
            usbeth_pkg::OP_PKT_END:  cls.kind = usbeth_pkg::CMD_PKT_END;
            usbeth_pkg::OP_XFER_ERR: cls.kind = usbeth_pkg::CMD_XFER_ERR;
            default:                 keep = 1'b0;
         endcase
      end
   end

   assign full = (count_ff == usbeth_pkg::CMD_CW'(usbeth_pkg::CMD_DEPTH));
   assign wr_en = push && !full && keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd = q_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + usbeth_pkg::CMD_AW'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + usbeth_pkg::CMD_AW'(1);
      end
      if (wr_en && !cmd_pop) begin
         count_in = count_ff + usbeth_pkg::CMD_CW'(1);
      end else if (!wr_en && cmd_pop) begin
         count_in = count_ff - usbeth_pkg::CMD_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Hold queue entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/core/usbeth_back.sv
`include "usb_bulk_to_ethernet_frame_assembler_defines.svh"

module usbeth_back #(
   parameter int FRAME_BYTES = usbeth_pkg::FRAME_BYTES_DEF,
   parameter int MIN_FRAME = usbeth_pkg::MIN_FRAME_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  usbeth_pkg::cmd_type            cmd,
   output logic                           cmd_pop,
   input  logic [10:0]                    max_packet_size,
   input  logic [usbeth_pkg::RSP_CW-1:0]  rsp_count,
   output logic                           res_valid,
   output usbeth_pkg::result_type         res
);

   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int AW = $clog2(FRAME_BYTES);

   logic [7:0] mem [FRAME_BYTES];
   logic [7:0] rd_data_ff;

   logic [CW-1:0] fc_ff, fc_in;
   logic [10:0]   pc_ff, pc_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] rl_ff, rl_in;
   logic [7:0]    etype_hi_ff, etype_hi_in;
   logic [7:0]    etype_lo_ff, etype_lo_in;

   logic                        s2_valid_ff, s2_valid_in;
   usbeth_pkg::result_kind_type s2_kind_ff, s2_kind_in;
   logic [CW-1:0]               s2_len_ff, s2_len_in;
   logic                        s2_last_ff, s2_last_in;
   logic                        s2_use_mem_ff, s2_use_mem_in;

   logic          wr_en;
   logic [CW-1:0] idx_next;
   logic          read_last;
   logic          type_ok;
   logic          end_pkt;
   logic [CW-1:0] padded_len;

   // Take a command only when the result queue has room for it
   assign cmd_pop = cmd_valid
      && ((rsp_count + usbeth_pkg::RSP_CW'(s2_valid_ff))
          < usbeth_pkg::RSP_CW'(usbeth_pkg::RSP_DEPTH));

   assign idx_next = idx_ff + CW'(1);
   assign read_last = (idx_next >= rl_ff);
   assign type_ok = (fc_ff >= CW'(usbeth_pkg::HEADER_BYTES))
      && (({etype_hi_ff, etype_lo_ff} == usbeth_pkg::TYPE_IPV4)
          || ({etype_hi_ff, etype_lo_ff} == usbeth_pkg::TYPE_ARP));
   assign end_pkt = (pc_ff == '0) || (pc_ff < max_packet_size)
      || (fc_ff >= CW'(FRAME_BYTES));
   assign padded_len = (fc_ff < CW'(MIN_FRAME)) ? CW'(MIN_FRAME) : fc_ff;

   // Carry out one command
   always_comb begin
      fc_in = fc_ff;
      pc_in = pc_ff;
      pend_in = pend_ff;
      idx_in = idx_ff;
      rl_in = rl_ff;
      etype_hi_in = etype_hi_ff;
      etype_lo_in = etype_lo_ff;
      wr_en = 1'b0;
      s2_valid_in = 1'b0;
      s2_kind_in = usbeth_pkg::KIND_DATA;
      s2_len_in = '0;
      s2_last_in = 1'b0;
      s2_use_mem_in = 1'b0;
      if (cmd_pop) begin
         if (cmd.kind == usbeth_pkg::CMD_READ) begin
            if (pend_ff) begin
               s2_valid_in = 1'b1;
               s2_kind_in = usbeth_pkg::KIND_DATA;
               s2_len_in = rl_ff;
               s2_use_mem_in = (idx_ff < fc_ff);
               s2_last_in = read_last;
               if (read_last) begin
                  pend_in = 1'b0;
                  fc_in = '0;
                  pc_in = '0;
                  idx_in = '0;
               end else begin
                  idx_in = idx_next;
               end
            end
         end else if (!pend_ff) begin
            unique case (cmd.kind) inside
               usbeth_pkg::CMD_LINK_DOWN, usbeth_pkg::CMD_XFER_ERR: begin
                  fc_in = '0;
                  pc_in = '0;
               end
               usbeth_pkg::CMD_DATA: begin
                  if (fc_ff < CW'(FRAME_BYTES)) begin
                     wr_en = 1'b1;
                     fc_in = fc_ff + CW'(1);
                     if (fc_ff == CW'(usbeth_pkg::ETYPE_HI_POS)) begin
                        etype_hi_in = cmd.data;
                     end
                     if (fc_ff == CW'(usbeth_pkg::ETYPE_LO_POS)) begin
                        etype_lo_in = cmd.data;
                     end
                  end
                  if (pc_ff != usbeth_pkg::PKT_SAT) begin
                     pc_in = pc_ff + 11'd1;
                  end
               end
               usbeth_pkg::CMD_PKT_END: begin
                  pc_in = '0;
                  if (end_pkt) begin
                     s2_valid_in = 1'b1;
                     if (type_ok) begin
                        rl_in = padded_len;
                        idx_in = '0;
                        pend_in = 1'b1;
                        s2_kind_in = usbeth_pkg::KIND_READY;
                        s2_len_in = padded_len;
                     end else begin
                        fc_in = '0;
                        s2_kind_in = usbeth_pkg::KIND_DISCARD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= '0;
         pc_ff <= '0;
         pend_ff <= 1'b0;
         idx_ff <= '0;
         rl_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         fc_ff <= fc_in;
         pc_ff <= pc_in;
         pend_ff <= pend_in;
         idx_ff <= idx_in;
         rl_ff <= rl_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Hold result payload and captured header bytes
   always_ff @(posedge clock) begin
      etype_hi_ff <= etype_hi_in;
      etype_lo_ff <= etype_lo_in;
      s2_kind_ff <= s2_kind_in;
      s2_len_ff <= s2_len_in;
      s2_last_ff <= s2_last_in;
      s2_use_mem_ff <= s2_use_mem_in;
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fc_ff[AW-1:0]] <= cmd.data;
      end
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   // Build the result word; padding reads as zero
   assign res_valid = s2_valid_ff;
   always_comb begin
      res.kind = s2_kind_ff;
      res.length = 12'(s2_len_ff);
      res.data = s2_use_mem_ff ? rd_data_ff : 8'd0;
      res.last = s2_last_ff;
   end

   `USBETH_ASSERT_NEXT(a_pend_hold, clock, reset, pend_ff && !(cmd_pop && (cmd.kind == usbeth_pkg::CMD_READ) && read_last), $stable(fc_ff) && pend_ff)
   `USBETH_ASSERT_IMPLY(a_idx_range, clock, reset, pend_ff, (idx_ff < rl_ff) && (rl_ff >= CW'(MIN_FRAME)))
   `USBETH_ASSERT_IMPLY(a_fc_range, clock, reset, 1'b1, fc_ff <= CW'(FRAME_BYTES))

endmodule

FILE: rtl/core/usbeth_rsp_queue.sv
`include "usb_bulk_to_ethernet_frame_assembler_defines.svh"

module usbeth_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  usbeth_pkg::result_type        res,
   input  logic                          pop,
   output logic                          empty,
   output usbeth_pkg::result_type        head,
   output logic [usbeth_pkg::RSP_CW-1:0] count
);

   usbeth_pkg::result_type          q_ff [usbeth_pkg::RSP_DEPTH];
   logic [usbeth_pkg::RSP_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [usbeth_pkg::RSP_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [usbeth_pkg::RSP_CW-1:0]   count_ff, count_in;
   logic                            rd_en;

   assign empty = (count_ff == '0);
   assign rd_en = pop && !empty;
   assign head = q_ff[rd_ptr_ff];
   assign count = count_ff;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (res_valid) begin
         wr_ptr_in = wr_ptr_ff + usbeth_pkg::RSP_AW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + usbeth_pkg::RSP_AW'(1);
      end
      if (res_valid && !rd_en) begin
         count_in = count_ff + usbeth_pkg::RSP_CW'(1);
      end else if (!res_valid && rd_en) begin
         count_in = count_ff - usbeth_pkg::RSP_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Hold result words
   always_ff @(posedge clock) begin
      if (res_valid) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

   `USBETH_ASSERT_IMPLY(a_no_overflow, clock, reset, res_valid && !rd_en, count_ff != usbeth_pkg::RSP_CW'(usbeth_pkg::RSP_DEPTH))

endmodule

FILE: rtl/core/usb_bulk_to_ethernet_frame_assembler.sv
// USB bulk IN to Ethernet frame assembler.
// Input channel: push/full queue carrying opcode, data byte and link state.
// A word is taken at a clock edge with push high and full low. Data bytes
// are gathered into a frame store; a short or empty packet, or a full store,
// ends the frame. IPv4 and ARP frames are announced with their padded length
// and then read out one byte per read word; other frames are discarded.
// Result channel: empty/pop queue; the oldest result sits on the rsp_ ports
// while empty is low and leaves at an edge with pop high.
// A result passes the command queue, then the back end's result and frame
// store read registers, then the result queue. Throughput is one word per
// cycle while the result queue has room, set by the back end, which carries
// out one command per cycle with at most one frame store write or read.
// When pop stays low, the 4-entry result queue fills, the back end stops,
// the 2-entry command queue fills and full rises; nothing is lost.
// Reset empties both queues, clears the frame state and sets
// max_packet_size to 64; the frame store needs no clearing pass.
// Configuration: APB register max_packet_size at byte address 0. It is to
// be written only while the block is idle; the user must see to this.
module usb_bulk_to_ethernet_frame_assembler #(
   parameter int FRAME_BYTES = usbeth_pkg::FRAME_BYTES_DEF,
   parameter int MIN_FRAME = usbeth_pkg::MIN_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_link_up,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [11:0] rsp_frame_length,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [10:0] mps_ff, mps_in;
   logic        csr_wr;

   logic                                cmd_valid;
   usbeth_pkg::cmd_type                 cmd;
   logic                                cmd_pop;
   logic                                res_valid;
   usbeth_pkg::result_type              res;
   usbeth_pkg::result_type              head;
   logic [usbeth_pkg::RSP_CW-1:0]       rsp_count;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite
      && (paddr[2] == usbeth_pkg::REG_MAX_PACKET_SIZE);
   assign mps_in = csr_wr ? pwdata[10:0] : mps_ff;
   assign prdata = (paddr[2] == usbeth_pkg::REG_MAX_PACKET_SIZE)
      ? {21'd0, mps_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mps_ff <= usbeth_pkg::MPS_RESET;
      end else begin
         mps_ff <= mps_in;
      end
   end

   usbeth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .opcode    (req_opcode),
      .data_byte (req_data_byte),
      .link_up   (req_link_up),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   usbeth_back #(
      .FRAME_BYTES (FRAME_BYTES),
      .MIN_FRAME   (MIN_FRAME)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .max_packet_size (mps_ff),
      .rsp_count       (rsp_count),
      .res_valid       (res_valid),
      .res             (res)
   );

   usbeth_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .pop       (pop),
      .empty     (empty),
      .head      (head),
      .count     (rsp_count)
   );

   // Drive result ports from the queue head
   assign rsp_result_kind = head.kind;
   assign rsp_frame_length = head.length;
   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_RESULTS = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS = 210;
   localparam int SHOWN_MISMATCHES = 10;
   // opcodes outside the defined set behave like a NAK
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data;
      logic       link;
   } req_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_link_up = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [11:0] rsp_frame_length;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   usb_bulk_to_ethernet_frame_assembler DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_opcode(req_opcode), .req_data_byte(req_data_byte), .req_link_up(req_link_up),
      .empty(empty), .pop(pop),
      .rsp_result_kind(rsp_result_kind), .rsp_frame_length(rsp_frame_length),
      .rsp_out_byte(rsp_out_byte), .rsp_out_last(rsp_out_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // Frame assembly state mirrored from the block
   logic [7:0]  frame_mem [0:usbeth_pkg::FRAME_BYTES_DEF-1];
   int          fill_count = 0;
   int          pkt_bytes = 0;
   bit          frame_ready = 1'b0;
   int          read_pos = 0;
   int          read_len = 0;
   logic [10:0] mps_reg = usbeth_pkg::MPS_RESET;

   usbeth_pkg::result_type due_results[$];
   req_word_type           req_words[$];
   req_word_type           next_word;
   usbeth_pkg::result_type head_result;
   int          gen_words = 0;
   int          mismatches = 0;
   int          results_seen = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles = 0;

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
         $display("%s", msg);
   endtask

   // Advance the frame state by one accepted word and queue the result it causes
   task automatic assemble_word(input logic [2:0] op, input logic [7:0] data, input logic link);
      usbeth_pkg::result_type r;
      logic [15:0] etype;
      r = '0;
      if (op == usbeth_pkg::OP_READ) begin
         if (frame_ready) begin
            r.kind = usbeth_pkg::KIND_DATA;
            r.length = 12'(read_len);
            r.data = (read_pos < fill_count) ? frame_mem[read_pos] : 8'h00;
            r.last = (read_pos + 1 >= read_len);
            due_results.push_back(r);
            if (r.last) begin
               frame_ready = 1'b0;
               fill_count = 0;
               pkt_bytes = 0;
               read_pos = 0;
            end else begin
               read_pos++;
            end
         end
      end else if (!frame_ready) begin
         if (!link) begin
            fill_count = 0;
            pkt_bytes = 0;
         end else begin
            case (op)
               usbeth_pkg::OP_DATA: begin
                  if (fill_count < usbeth_pkg::FRAME_BYTES_DEF) begin
                     frame_mem[fill_count] = data;
                     fill_count++;
                  end
                  if (pkt_bytes < int'(usbeth_pkg::PKT_SAT))
                     pkt_bytes++;
               end
               usbeth_pkg::OP_PKT_END: begin
                  if (pkt_bytes == 0 || pkt_bytes < int'(mps_reg) ||
                      fill_count >= usbeth_pkg::FRAME_BYTES_DEF) begin
                     // close the frame: keep IPv4 and ARP, drop the rest
                     pkt_bytes = 0;
                     etype = '0;
                     if (fill_count >= usbeth_pkg::HEADER_BYTES)
                        etype = {frame_mem[usbeth_pkg::ETYPE_HI_POS],
                                 frame_mem[usbeth_pkg::ETYPE_LO_POS]};
                     if (fill_count >= usbeth_pkg::HEADER_BYTES &&
                         (etype == usbeth_pkg::TYPE_IPV4 ||
                          etype == usbeth_pkg::TYPE_ARP)) begin
                        read_len = (fill_count < usbeth_pkg::MIN_FRAME_DEF)
                           ? usbeth_pkg::MIN_FRAME_DEF : fill_count;
                        read_pos = 0;
                        frame_ready = 1'b1;
                        r.kind = usbeth_pkg::KIND_READY;
                        r.length = 12'(read_len);
                     end else begin
                        fill_count = 0;
                        r.kind = usbeth_pkg::KIND_DISCARD;
                     end
                     due_results.push_back(r);
                  end else begin
                     pkt_bytes = 0;
                  end
               end
               usbeth_pkg::OP_XFER_ERR: begin
                  fill_count = 0;
                  pkt_bytes = 0;
               end
               default: ;
            endcase
         end
      end
   endtask

   task automatic add_word(input logic [2:0] op, input logic [7:0] data, input logic link);
      req_words.push_back('{opcode: op, data: data, link: link});
      gen_words++;
   endtask

   // Queue one frame cut into packets of split bytes, closed by a short or empty
   // packet, followed by enough reads to drain it and a few spare reads
   task automatic add_frame(input int len, input bit good, input int split);
      int in_pkt;
      int kept;
      int n_reads;
      logic [15:0] etype;
      logic [7:0] b;
      if (good)
         etype = $urandom_range(1) ? usbeth_pkg::TYPE_IPV4 : usbeth_pkg::TYPE_ARP;
      else
         etype = 16'($urandom);
      in_pkt = 0;
      for (int i = 0; i < len; i++) begin
         if (i == usbeth_pkg::ETYPE_HI_POS)
            b = etype[15:8];
         else if (i == usbeth_pkg::ETYPE_LO_POS)
            b = etype[7:0];
         else
            b = 8'($urandom);
         add_word(usbeth_pkg::OP_DATA, b, 1'b1);
         in_pkt++;
         // sprinkle NAKs and spare opcodes between bytes
         if ($urandom_range(15) == 0)
            add_word($urandom_range(1) ? usbeth_pkg::OP_NAK :
                     3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                     8'($urandom), 1'b1);
         if (in_pkt == split) begin
            add_word(usbeth_pkg::OP_PKT_END, 8'($urandom), 1'b1);
            in_pkt = 0;
         end
      end
      add_word(usbeth_pkg::OP_PKT_END, 8'($urandom), 1'b1);
      // a full-size last packet needs a zero-length packet to close the frame
      if (in_pkt != 0 && in_pkt >= int'(mps_reg) && len < usbeth_pkg::FRAME_BYTES_DEF)
         add_word(usbeth_pkg::OP_PKT_END, 8'($urandom), 1'b1);
      kept = (len < usbeth_pkg::FRAME_BYTES_DEF) ? len : usbeth_pkg::FRAME_BYTES_DEF;
      n_reads = 0;
      if (good && len >= usbeth_pkg::HEADER_BYTES)
         n_reads = (kept < usbeth_pkg::MIN_FRAME_DEF) ? usbeth_pkg::MIN_FRAME_DEF : kept;
      n_reads += $urandom_range(2);
      repeat (n_reads) begin
         // writes while the frame is held must be ignored
         if ($urandom_range(15) == 0)
            add_word(3'($urandom_range(usbeth_pkg::OP_XFER_ERR)), 8'($urandom),
                     1'($urandom));
         add_word(usbeth_pkg::OP_READ, 8'($urandom), 1'($urandom));
      end
   endtask

   // Mostly well-formed frames, some cut short, some random noise
   task automatic add_traffic(input int budget);
      int start_n;
      int pick;
      int split;
      int len;
      start_n = gen_words;
      while (gen_words - start_n < budget) begin
         pick = $urandom_range(99);
         if (mps_reg == 0)
            split = $urandom_range(64, 1);
         else if ($urandom_range(7) == 0)
            split = int'(mps_reg) + $urandom_range(20, 1);
         else
            split = int'(mps_reg);
         len = ($urandom_range(9) == 0) ? $urandom_range(300, 91) : $urandom_range(90);
         if (pick < 75) begin
            add_frame(len, $urandom_range(99) < 85, split);
         end else if (pick < 87) begin
            repeat ($urandom_range(30, 1))
               add_word(usbeth_pkg::OP_DATA, 8'($urandom), 1'b1);
            if ($urandom_range(1))
               add_word(usbeth_pkg::OP_XFER_ERR, 8'($urandom), 1'b1);
            else
               add_word(3'($urandom_range(usbeth_pkg::OP_XFER_ERR)), 8'($urandom), 1'b0);
         end else begin
            repeat ($urandom_range(8, 1))
               add_word(3'($urandom), 8'($urandom), 1'($urandom_range(9) != 0));
            add_word(usbeth_pkg::OP_XFER_ERR, 8'($urandom), 1'b1);
         end
      end
   endtask

   // Write max_packet_size, then read it back
   task automatic write_mps(input logic [10:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {usbeth_pkg::REG_MAX_PACKET_SIZE, 2'b00};
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      mps_reg = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== 32'(value))
         log_mismatch($sformatf("max_packet_size reads %0d, wrote %0d", prdata, value));
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Wait until every queued word is taken and every result has come back
   task automatic drain();
      while (req_words.size() != 0 || push || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Input driver: load the next word whenever the slot is free
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full)
            assemble_word(req_opcode, req_data_byte, req_link_up);
         if (!push || !full) begin
            if (req_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = req_words.pop_front();
               req_opcode <= next_word.opcode;
               req_data_byte <= next_word.data;
               req_link_up <= next_word.link;
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each word taken, hold off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (due_results.size() == 0) begin
               log_mismatch($sformatf("unexpected result: kind %0d len %0d byte %02h last %0b",
                  rsp_result_kind, rsp_frame_length, rsp_out_byte, rsp_out_last));
            end else begin
               head_result = due_results.pop_front();
               if (rsp_result_kind !== head_result.kind ||
                   rsp_frame_length !== head_result.length ||
                   rsp_out_byte !== head_result.data || rsp_out_last !== head_result.last)
                  log_mismatch($sformatf(
                     "result %0d: got kind %0d len %0d byte %02h last %0b, want %0d %0d %02h %0b",
                     results_seen, rsp_result_kind, rsp_frame_length, rsp_out_byte,
                     rsp_out_last, head_result.kind, head_result.length, head_result.data,
                     head_result.last));
            end
         end
         if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: stop when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("usb_bulk_to_ethernet_frame_assembler: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Phases: packet size settings and idle patterns
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_idle_pct = 33;
            recv_idle_pct = 63;
         end else if (ph < 4) begin
            send_idle_pct = 63;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            1: write_mps(11'd1);
            2: write_mps(11'd1024);
            3: write_mps(11'd0);
            4: write_mps(11'd2047);
            5: write_mps(11'($urandom_range(200, 2)));
            default: ;
         endcase
         if (ph == 0) begin
            // read with no frame held gives nothing
            add_word(usbeth_pkg::OP_READ, 8'hFF, 1'b1);
            // empty frame closed by a zero-length packet is discarded
            add_word(usbeth_pkg::OP_PKT_END, 8'h00, 1'b1);
            // transfer error drops the bytes gathered so far
            add_word(usbeth_pkg::OP_DATA, 8'hFF, 1'b1);
            add_word(usbeth_pkg::OP_DATA, 8'h00, 1'b1);
            add_word(usbeth_pkg::OP_XFER_ERR, 8'h5A, 1'b1);
            add_word(usbeth_pkg::OP_PKT_END, 8'hA5, 1'b1);
            // dropped link clears the partial frame
            add_word(usbeth_pkg::OP_DATA, 8'h81, 1'b1);
            add_word(usbeth_pkg::OP_NAK, 8'h7E, 1'b0);
            add_word(usbeth_pkg::OP_PKT_END, 8'h00, 1'b1);
            // NAK and spare opcodes change nothing
            add_word(usbeth_pkg::OP_NAK, 8'hFF, 1'b1);
            for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
               add_word(3'(op), 8'h00, 1'b1);
            // frame one byte short of a header is discarded
            for (int i = 0; i < usbeth_pkg::HEADER_BYTES - 1; i++)
               add_word(usbeth_pkg::OP_DATA, (i == 0) ? 8'hFF : 8'(i), 1'b1);
            add_word(usbeth_pkg::OP_PKT_END, 8'h00, 1'b1);
         end
         add_traffic(PHASE_WORDS);
         drain();
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("usb_bulk_to_ethernet_frame_assembler: match");
      else
         $display("usb_bulk_to_ethernet_frame_assembler: mismatch");
      $finish;
   end

endmodule

FILE: usb_bulk_to_ethernet_frame_assembler.f
+incdir+rtl/core
rtl/core/usbeth_pkg.sv
rtl/core/usbeth_front.sv
rtl/core/usbeth_back.sv
rtl/core/usbeth_rsp_queue.sv
rtl/core/usb_bulk_to_ethernet_frame_assembler.sv
sim/tb_top.sv
